/* hw/rtl/tfl_pkg.sv */
// transfer function lookup: shared constants and types
// no dependencies
`default_nettype none
package tfl_pkg;
    localparam int MaxEntriesDefault   = 16;
    localparam int FractionBitsDefault = 16;
    localparam int PosW   = 16;
    localparam int ChanW  = 16;
    localparam int CountW = 5;
    localparam int IndexW = 4;
    localparam logic KIND_WRITE    = 1'b0;
    localparam logic KIND_CLASSIFY = 1'b1;
    typedef logic [ChanW-1:0] chan_t;
    typedef struct packed {
        chan_t r;
        chan_t g;
        chan_t b;
        chan_t a;
    } color_t;
endpackage
`default_nettype wire

/* hw/rtl/transfer_function_lookup.sv */
// transfer function lookup top level: table, search, divider, blend pipeline
// depends on tfl_pkg, tfl_divider
//
// channel | direction | handshake
// s_      | in        | s_valid / s_ready, table write or sample word
// cfg_    | in        | cfg_valid / cfg_ready, entry count
// m_      | out       | m_valid / m_ready, color word
//
// one word per cycle while the output is not stalled; a sample passes stage 1, stage 2,
// the bit-per-stage divider, stage 4 and stage 5; table writes leave no result
// the whole pipeline advances only when the output register is free or taken
// reset clears valid bits and entry count to 2; the table is undefined until written
`default_nettype none
module transfer_function_lookup #(
    parameter int MAX_ENTRIES   = tfl_pkg::MaxEntriesDefault,
    parameter int FRACTION_BITS = tfl_pkg::FractionBitsDefault
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [tfl_pkg::CountW-1:0] cfg_data,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic                   s_kind,
    input  wire logic [tfl_pkg::IndexW-1:0] s_entry_index,
    input  wire logic [tfl_pkg::PosW-1:0]  s_entry_position,
    input  wire logic [tfl_pkg::ChanW-1:0] s_entry_red,
    input  wire logic [tfl_pkg::ChanW-1:0] s_entry_green,
    input  wire logic [tfl_pkg::ChanW-1:0] s_entry_blue,
    input  wire logic [tfl_pkg::ChanW-1:0] s_entry_opacity,
    input  wire logic [tfl_pkg::PosW-1:0]  s_sample,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [tfl_pkg::ChanW-1:0]   m_out_red,
    output logic [tfl_pkg::ChanW-1:0]   m_out_green,
    output logic [tfl_pkg::ChanW-1:0]   m_out_blue,
    output logic [tfl_pkg::ChanW-1:0]   m_out_opacity,
    output logic                        m_clamped
);
    import tfl_pkg::*;

    localparam int IdxW  = $clog2(MAX_ENTRIES);
    localparam int NumW  = PosW + FRACTION_BITS;
    localparam int FW    = FRACTION_BITS + 1;
    localparam int TagW  = 1 + 2 * $bits(color_t);

    logic en;
    logic [CountW-1:0] count_reg;
    logic [PosW-1:0] pos_mem [MAX_ENTRIES];
    color_t          col_mem [MAX_ENTRIES];

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= CountW'(2);
        end else if (cfg_valid) begin
            count_reg <= cfg_data;
        end
    end

    assign s_ready = en;
    logic wr_ok;
    assign wr_ok = s_valid && en && s_kind == KIND_WRITE &&
                   32'(s_entry_index) < MAX_ENTRIES;
    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            pos_mem[IdxW'(s_entry_index)] <= s_entry_position;
            col_mem[IdxW'(s_entry_index)] <= {s_entry_red, s_entry_green,
                                              s_entry_blue, s_entry_opacity};
        end
    end

    // stage 1: compare sample against every breakpoint below the entry count, pick bracketing index
    logic              v1_reg, cl1_reg;
    logic [PosW-1:0]   s1_reg;
    logic [IdxW-1:0]   j1_reg;
    logic [IdxW:0]     n_eff;
    logic [MAX_ENTRIES-1:0] gt;
    logic [IdxW-1:0]   jsel;
    logic              found, below;
    always_comb begin
        if (count_reg < CountW'(2)) begin
            n_eff = (IdxW+1)'(2);
        end else if (32'(count_reg) > MAX_ENTRIES) begin
            n_eff = (IdxW+1)'(MAX_ENTRIES);
        end else begin
            n_eff = (IdxW+1)'(count_reg);
        end
    end
    always_comb begin
        for (int k = 0; k < MAX_ENTRIES; k++) begin
            gt[k] = pos_mem[k] > s_sample && k < 32'(n_eff);
        end
        jsel  = '0;
        found = 1'b0;
        for (int k = MAX_ENTRIES - 1; k >= 1; k--) begin
            if (gt[k]) begin
                jsel  = IdxW'(k);
                found = 1'b1;
            end
        end
        below = gt[0];
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid && s_kind == KIND_CLASSIFY;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg  <= s_sample;
            cl1_reg <= below || !found;
            if (below) begin
                j1_reg <= '0;
            end else if (!found) begin
                j1_reg <= IdxW'(n_eff - 1'b1);
            end else begin
                j1_reg <= jsel;
            end
        end
    end

    // stage 2: fetch bracketing entries
    logic              v3_reg, cl3_reg;
    logic [NumW-1:0]   num3_reg;
    logic [PosW-1:0]   den3_reg;
    color_t            ca3_reg, cb3_reg;
    logic [IdxW-1:0]   ilo;
    logic [PosW-1:0]   plo;
    assign ilo = cl1_reg ? j1_reg : j1_reg - 1'b1;
    assign plo = pos_mem[ilo];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v1_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            cl3_reg  <= cl1_reg;
            ca3_reg  <= col_mem[ilo];
            cb3_reg  <= col_mem[j1_reg];
            num3_reg <= cl1_reg ? '0 : {s1_reg - plo, {FRACTION_BITS{1'b0}}};
            den3_reg <= cl1_reg ? PosW'(1) : pos_mem[j1_reg] - plo;
        end
    end

    logic            dv;
    logic [NumW-1:0] dq;
    logic [TagW-1:0] dtag;
    tfl_divider #(.NumW(NumW), .DenW(PosW), .TagW(TagW)) u_div (
        .aclk, .aresetn, .en,
        .in_valid(v3_reg), .in_num(num3_reg), .in_den(den3_reg),
        .in_tag({cl3_reg, ca3_reg, cb3_reg}),
        .out_valid(dv), .out_quo(dq), .out_tag(dtag)
    );

    // stage 4: products
    color_t ca, cb;
    logic   cl;
    assign {cl, ca, cb} = dtag;
    logic [FW-1:0] f, fi;
    assign f  = FW'(dq);
    assign fi = FW'(1) << FRACTION_BITS;
    logic v4_reg, cl4_reg;
    color_t cc4_reg;
    logic [ChanW+FW-1:0] pa4_reg [4], pb4_reg [4];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= dv;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            cl4_reg <= cl;
            cc4_reg <= ca;
            pa4_reg[0] <= ca.r * (fi - f);
            pa4_reg[1] <= ca.g * (fi - f);
            pa4_reg[2] <= ca.b * (fi - f);
            pa4_reg[3] <= ca.a * (fi - f);
            pb4_reg[0] <= cb.r * f;
            pb4_reg[1] <= cb.g * f;
            pb4_reg[2] <= cb.b * f;
            pb4_reg[3] <= cb.a * f;
        end
    end

    // stage 5: sum and output register
    logic [ChanW+FW:0] sm [4];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            sm[k] = (ChanW+FW+1)'(pa4_reg[k]) + (ChanW+FW+1)'(pb4_reg[k]);
        end
    end
    logic v5_reg, cl5_reg;
    color_t o5_reg;
    assign en = !v5_reg || m_ready;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            cl5_reg <= cl4_reg;
            if (cl4_reg) begin
                o5_reg <= cc4_reg;
            end else begin
                o5_reg <= {ChanW'(sm[0] >> FRACTION_BITS), ChanW'(sm[1] >> FRACTION_BITS),
                           ChanW'(sm[2] >> FRACTION_BITS), ChanW'(sm[3] >> FRACTION_BITS)};
            end
        end
    end

    assign m_valid       = v5_reg;
    assign m_clamped     = cl5_reg;
    assign m_out_red     = o5_reg.r;
    assign m_out_green   = o5_reg.g;
    assign m_out_blue    = o5_reg.b;
    assign m_out_opacity = o5_reg.a;
endmodule
`default_nettype wire

/* hw/rtl/tfl_divider.sv */
// pipelined restoring divider, one quotient bit per stage, stall by enable
// depends on tfl_pkg
`default_nettype none
module tfl_divider #(
    parameter int NumW   = 32,
    parameter int DenW   = 16,
    parameter int TagW   = 8
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire logic [NumW-1:0] in_num,
    input  wire logic [DenW-1:0] in_den,
    input  wire logic [TagW-1:0] in_tag,
    output logic                 out_valid,
    output logic [NumW-1:0]      out_quo,
    output logic [TagW-1:0]      out_tag
);
    import tfl_pkg::*;

    logic [NumW:1]          valid_reg;
    logic [NumW-1:0]        num_reg [1:NumW];
    logic [DenW:0]          rem_reg [1:NumW];
    logic [DenW-1:0]        den_reg [1:NumW];
    logic [TagW-1:0]        tag_reg [1:NumW];

    for (genvar k = 0; k < NumW; k++) begin : g_stage
        logic            v_cur;
        logic [NumW-1:0] num_cur;
        logic [DenW:0]   rem_cur;
        logic [DenW-1:0] den_cur;
        logic [TagW-1:0] tag_cur;
        logic [DenW+1:0] trial;
        logic [DenW+1:0] sub;
        if (k == 0) begin : g_first
            assign v_cur   = in_valid;
            assign num_cur = in_num;
            assign rem_cur = '0;
            assign den_cur = in_den;
            assign tag_cur = in_tag;
        end else begin : g_next
            assign v_cur   = valid_reg[k];
            assign num_cur = num_reg[k];
            assign rem_cur = rem_reg[k];
            assign den_cur = den_reg[k];
            assign tag_cur = tag_reg[k];
        end
        assign trial = {rem_cur, num_cur[NumW-1]};
        assign sub   = trial - {2'b00, den_cur};
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                valid_reg[k+1] <= v_cur;
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg[k+1] <= den_cur;
                tag_reg[k+1] <= tag_cur;
                if (!sub[DenW+1]) begin
                    rem_reg[k+1] <= sub[DenW:0];
                    num_reg[k+1] <= {num_cur[NumW-2:0], 1'b1};
                end else begin
                    rem_reg[k+1] <= trial[DenW:0];
                    num_reg[k+1] <= {num_cur[NumW-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = valid_reg[NumW];
    assign out_quo   = num_reg[NumW];
    assign out_tag   = tag_reg[NumW];
endmodule
`default_nettype wire

/* hw/rtl/tfl_checker.sv */
// port-level checks for transfer_function_lookup, bound to the top level
// depends on tfl_pkg
`default_nettype none
module tfl_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire logic m_clamped,
    input wire logic [15:0] m_out_red
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_red) && $stable(m_clamped))
        else $error("result dropped while stalled");
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while output stalled");
    a_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output");
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("valid after reset");
endmodule
bind transfer_function_lookup tfl_checker u_chk (.*);
`default_nettype wire

/* tb/tb_transfer_function_lookup.sv */
// testbench for transfer_function_lookup: table loads, samples and count changes
// depends on tfl_pkg and the transfer_function_lookup rtl; self-checking, no files
`default_nettype none
module tb_transfer_function_lookup;
    timeunit 1ns;
    timeprecision 1ps;
    import tfl_pkg::*;

    localparam int Entries   = 16;
    localparam int FracBits  = 16;
    localparam int DrainWait = FracBits + PosW + 20;
    localparam int CycleCap  = 400000;

    typedef struct {
        logic              kind;
        logic [IndexW-1:0] slot;
        logic [PosW-1:0]   pos;
        chan_t             r, g, b, a;
        logic [PosW-1:0]   smp;
    } word_t;

    typedef struct {
        chan_t r, g, b, a;
        logic  clamped;
    } shade_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CountW-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_kind = 1'b0;
    logic [IndexW-1:0] s_entry_index = '0;
    logic [PosW-1:0] s_entry_position = '0;
    chan_t s_entry_red = '0, s_entry_green = '0, s_entry_blue = '0, s_entry_opacity = '0;
    logic [PosW-1:0] s_sample = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    chan_t m_out_red, m_out_green, m_out_blue, m_out_opacity;
    logic m_clamped;

    transfer_function_lookup uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .s_entry_index(s_entry_index), .s_entry_position(s_entry_position),
        .s_entry_red(s_entry_red), .s_entry_green(s_entry_green),
        .s_entry_blue(s_entry_blue), .s_entry_opacity(s_entry_opacity),
        .s_sample(s_sample),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_red(m_out_red), .m_out_green(m_out_green),
        .m_out_blue(m_out_blue), .m_out_opacity(m_out_opacity),
        .m_clamped(m_clamped)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    word_t  pending_words[$];
    shade_t expected_shades[$];
    word_t  cur_word;
    logic [PosW-1:0] bp_pos[Entries];
    color_t bp_col[Entries];
    logic [PosW-1:0] plan_pos[Entries];
    logic [CountW-1:0] live_count;
    bit quiet = 1'b0;
    int errors = 0;
    int cycles = 0;

    function automatic chan_t mix(chan_t lo, chan_t hi, longint unsigned f);
        longint unsigned one;
        one = 64'd1 << FracBits;
        return chan_t'((longint'(lo) * (one - f) + longint'(hi) * f) >> FracBits);
    endfunction

    function automatic shade_t classify(logic [PosW-1:0] s);
        shade_t res;
        int n;
        int j;
        longint unsigned f;
        color_t ca, cb;
        n = live_count < 2 ? 2 : (live_count > Entries ? Entries : int'(live_count));
        res.clamped = 1'b1;
        if (s < bp_pos[0]) begin
            ca = bp_col[0];
            res.r = ca.r; res.g = ca.g; res.b = ca.b; res.a = ca.a;
            return res;
        end
        for (j = 1; j < n; j++)
            if (bp_pos[j] > s) break;
        if (j == n) begin
            ca = bp_col[n-1];
            res.r = ca.r; res.g = ca.g; res.b = ca.b; res.a = ca.a;
            return res;
        end
        f = (longint'(s - bp_pos[j-1]) << FracBits) / longint'(bp_pos[j] - bp_pos[j-1]);
        ca = bp_col[j-1];
        cb = bp_col[j];
        res.r = mix(ca.r, cb.r, f);
        res.g = mix(ca.g, cb.g, f);
        res.b = mix(ca.b, cb.b, f);
        res.a = mix(ca.a, cb.a, f);
        res.clamped = 1'b0;
        return res;
    endfunction

    function automatic word_t rand_word(logic kind);
        word_t w;
        w.kind = kind;
        w.slot = IndexW'($urandom);
        w.pos = PosW'($urandom);
        w.r = chan_t'($urandom); w.g = chan_t'($urandom);
        w.b = chan_t'($urandom); w.a = chan_t'($urandom);
        w.smp = PosW'($urandom);
        return w;
    endfunction

    function automatic void push_entry(int slot, logic [PosW-1:0] p, bit extreme);
        word_t w;
        w = rand_word(KIND_WRITE);
        w.slot = IndexW'(slot);
        w.pos = p;
        if (extreme) begin
            w.r = '0; w.g = '1; w.b = (slot % 2) ? '1 : '0; w.a = (slot % 2) ? '0 : '1;
        end
        plan_pos[slot] = p;
        pending_words.push_back(w);
    endfunction

    function automatic void load_table(bit ascending);
        int p;
        p = $urandom_range(0, 300);
        for (int k = 0; k < Entries; k++) begin
            if (ascending) begin
                push_entry(k, PosW'(p), 1'b0);
                p += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4000);
            end else begin
                push_entry(k, PosW'($urandom), 1'b0);
            end
        end
    endfunction

    function automatic void push_sample(logic [PosW-1:0] s);
        word_t w;
        w = rand_word(KIND_CLASSIFY);
        w.smp = s;
        pending_words.push_back(w);
    endfunction

    function automatic void push_random(int count);
        int k;
        int gap;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 9))
                0: pending_words.push_back(rand_word(KIND_CLASSIFY));
                1: begin
                    k = $urandom_range(0, Entries - 1);
                    push_entry(k, PosW'($urandom), 1'b0);
                end
                default: begin
                    k = $urandom_range(0, Entries - 1);
                    gap = (k < Entries - 1 && plan_pos[k+1] > plan_pos[k])
                        ? plan_pos[k+1] - plan_pos[k] : 3;
                    push_sample(PosW'(plan_pos[k] + $urandom_range(0, gap)));
                end
            endcase
        end
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (cur_word.kind == KIND_WRITE) begin
                    bp_pos[cur_word.slot] = cur_word.pos;
                    bp_col[cur_word.slot] = {cur_word.r, cur_word.g, cur_word.b, cur_word.a};
                end else begin
                    expected_shades.push_back(classify(cur_word.smp));
                end
            end
            if (!s_valid || s_ready) begin
                if (pending_words.size() > 0 && (quiet || $urandom_range(0, 99) >= 22)) begin
                    cur_word = pending_words.pop_front();
                    s_kind <= cur_word.kind;
                    s_entry_index <= cur_word.slot;
                    s_entry_position <= cur_word.pos;
                    s_entry_red <= cur_word.r;
                    s_entry_green <= cur_word.g;
                    s_entry_blue <= cur_word.b;
                    s_entry_opacity <= cur_word.a;
                    s_sample <= cur_word.smp;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        shade_t e;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_shades.size() == 0) begin
                    $display("%0t: unexpected color word r=%h g=%h b=%h a=%h c=%b", $time,
                        m_out_red, m_out_green, m_out_blue, m_out_opacity, m_clamped);
                    errors++;
                end else begin
                    e = expected_shades.pop_front();
                    if (e.r !== m_out_red || e.g !== m_out_green || e.b !== m_out_blue ||
                            e.a !== m_out_opacity || e.clamped !== m_clamped) begin
                        $display("%0t: expected r=%h g=%h b=%h a=%h c=%b, got r=%h g=%h b=%h a=%h c=%b",
                            $time, e.r, e.g, e.b, e.a, e.clamped, m_out_red, m_out_green,
                            m_out_blue, m_out_opacity, m_clamped);
                        errors++;
                    end
                end
            end
            m_ready <= quiet || $urandom_range(0, 99) >= 22;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CycleCap) begin
            $display("tb_transfer_function_lookup NOT OK");
            $finish;
        end
    end

    task automatic write_count(logic [CountW-1:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        live_count = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        do @(posedge aclk);
        while (pending_words.size() > 0 || s_valid || expected_shades.size() > 0);
        repeat (DrainWait) @(posedge aclk);
    endtask

    initial begin
        logic [CountW-1:0] counts[10];
        counts = '{5'd2, 5'd31, 5'd0, 5'd1, 5'd17, 5'd5, 5'd9, 5'd14, 5'd3, 5'd16};
        live_count = 5'd2;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        // directed: default count, extreme colors, edges of the sample range
        for (int k = 0; k < Entries; k++)
            push_entry(k, (k == 0) ? PosW'(16) : (k == 1) ? PosW'('hFFFF) : PosW'(k * 4000),
                1'b1);
        push_sample('0);
        push_sample(PosW'(16));
        push_sample(PosW'(17));
        push_sample(PosW'('h8000));
        push_sample(PosW'('hFFFE));
        push_sample(PosW'('hFFFF));
        drain();
        write_count(5'd16);
        push_sample(PosW'(4000));
        push_sample(PosW'(6000));
        push_sample(PosW'(59999));
        push_sample(PosW'(60000));
        push_sample(PosW'(16));
        drain();
        for (int ph = 0; ph < 10; ph++) begin
            write_count(counts[ph]);
            quiet = (ph == 6);
            load_table(ph % 3 != 2);
            push_random(150);
            drain();
        end
        quiet = 1'b0;
        if (errors == 0)
            $display("tb_transfer_function_lookup OK");
        else
            $display("tb_transfer_function_lookup NOT OK");
        $finish;
    end
endmodule
`default_nettype wire
